FILE: design/fbrf_pkg.sv
// Shared constants, types and helpers for the frame store rectangle fill block.
package fbrf_pkg;

   localparam int MAX_COLS = 256;
   localparam int MAX_ROWS = 256;

   localparam int COL_W  = $clog2(MAX_COLS);
   localparam int ROW_W  = $clog2(MAX_ROWS);
   localparam int ADDR_W = $clog2(MAX_COLS * MAX_ROWS);
   localparam int DEPTH  = MAX_COLS * MAX_ROWS;

   localparam int SIZE_W  = 9;
   localparam int COORD_W = 11;
   localparam int COLOR_W = 16;
   localparam int CSR_AW  = 3;
   localparam int CSR_DW  = 32;

   localparam logic [SIZE_W-1:0] WIDTH_RESET  = 9'd240;
   localparam logic [SIZE_W-1:0] HEIGHT_RESET = 9'd240;

   typedef enum logic [1:0] {
      OP_DRAW = 2'd0,
      OP_FILL = 2'd1,
      OP_GET  = 2'd2,
      OP_NONE = 2'd3
   } op_type;

   typedef enum logic {
      REG_WIDTH  = 1'b0,
      REG_HEIGHT = 1'b1
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_FILL = 3'b010,
      ST_READ = 3'b100
   } state_type;

   function automatic logic [COLOR_W-1:0] swap16(input logic [COLOR_W-1:0] c);
      return {c[7:0], c[15:8]};
   endfunction

endpackage

FILE: design/framebuffer_pixel_rect_fill.sv
// Frame store with pixel draw, clipped rectangle fill and pixel read.
//
// Requests arrive on the req_ channel (valid/ready); each carries an op, a
// position, a rectangle size and a colour. Only a get pixel request produces
// a transfer on the rsp_ channel, carrying rsp_read_color.
// Draw pixel writes the frame memory at the edge the request is taken.
// Fill rectangle clips at acceptance, then writes one covered pixel per
// cycle through the single write port of the frame memory; req_ready is low
// while the fill runs. Get pixel reads the memory at acceptance into a read
// register and loads the output register once that is free, with req_ready
// low in between; requests that produce no response may be taken while a
// response waits. A second get waits until the output register is free.
// The csr_ port holds screen_width at byte 0 and screen_height at byte 4.
// Reset returns both to 240, clears the control state and empties the
// output register; the frame memory keeps its contents and a pixel never
// written reads as undefined. A stalled receiver holds rsp_valid and data.
module framebuffer_pixel_rect_fill (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [1:0]                   req_op,
   input  logic signed [10:0]           req_pos_x,
   input  logic signed [10:0]           req_pos_y,
   input  logic signed [10:0]           req_rect_w,
   input  logic signed [10:0]           req_rect_h,
   input  logic [15:0]                  req_pixel_color,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [15:0]                  rsp_read_color,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [fbrf_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [fbrf_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [fbrf_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                         csr_pready
);

   localparam int AW = fbrf_pkg::ADDR_W;
   localparam int CW = fbrf_pkg::COL_W;
   localparam int RW = fbrf_pkg::ROW_W;
   localparam int SW = fbrf_pkg::SIZE_W;
   localparam int DW = fbrf_pkg::COLOR_W;

   logic [DW-1:0] mem [0:fbrf_pkg::DEPTH-1];

   logic [SW-1:0] width_ff, width_in;
   logic [SW-1:0] height_ff, height_in;
   fbrf_pkg::state_type state_ff, state_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic [AW-1:0] row_start_ff, row_start_in;
   logic [CW-1:0] col_ff, col_in;
   logic [CW-1:0] col_last_ff, col_last_in;
   logic [RW-1:0] row_left_ff, row_left_in;
   logic [DW-1:0] color_ff, color_in;
   logic          on_screen_ff, on_screen_in;
   logic [DW-1:0] rdata_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0] rsp_color_ff, rsp_color_in;

   logic [SW-1:0] sw_eff, sh_eff;
   logic          req_xfer, cfg_write;
   logic          x_neg, y_neg, x_in, y_in, on_screen;
   logic [CW-1:0] x0;
   logic [RW-1:0] y0;
   logic [SW-1:0] avail_w, avail_h, wc, hc;
   logic          fill_empty;
   logic [AW-1:0] pix_addr, y_base;
   logic          mem_we, mem_re;
   logic [AW-1:0] mem_waddr;
   logic [DW-1:0] mem_wdata;
   logic          out_free;

   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (cfg_write) begin
         unique case (fbrf_pkg::reg_index_type'(csr_paddr[2]))
            fbrf_pkg::REG_WIDTH:  width_in  = csr_pwdata[SW-1:0];
            fbrf_pkg::REG_HEIGHT: height_in = csr_pwdata[SW-1:0];
            default:              width_in  = width_ff;
         endcase
      end
   end

   always_comb begin
      unique case (fbrf_pkg::reg_index_type'(csr_paddr[2]))
         fbrf_pkg::REG_WIDTH:  csr_prdata = fbrf_pkg::CSR_DW'(width_ff);
         fbrf_pkg::REG_HEIGHT: csr_prdata = fbrf_pkg::CSR_DW'(height_ff);
         default:              csr_prdata = '0;
      endcase
   end

   assign sw_eff = (10'(width_ff) > 10'(fbrf_pkg::MAX_COLS)) ?
                   SW'(fbrf_pkg::MAX_COLS) : width_ff;
   assign sh_eff = (10'(height_ff) > 10'(fbrf_pkg::MAX_ROWS)) ?
                   SW'(fbrf_pkg::MAX_ROWS) : height_ff;

   assign req_ready = (state_ff == fbrf_pkg::ST_IDLE);
   assign req_xfer  = req_valid & req_ready;

   // clip position against the screen
   assign x_neg     = req_pos_x[10];
   assign y_neg     = req_pos_y[10];
   assign x_in      = !x_neg && (req_pos_x[9:0] < 10'(sw_eff));
   assign y_in      = !y_neg && (req_pos_y[9:0] < 10'(sh_eff));
   assign on_screen = x_in & y_in;
   assign x0     = x_neg ? '0 : req_pos_x[CW-1:0];
   assign y0     = y_neg ? '0 : req_pos_y[RW-1:0];
   assign y_base = AW'(y0 * sw_eff);
   assign pix_addr = y_base + AW'(x0);

   assign avail_w = sw_eff - SW'(x0);
   assign avail_h = sh_eff - SW'(y0);
   assign wc = (req_rect_w[9:0] > 10'(avail_w)) ? avail_w : req_rect_w[SW-1:0];
   assign hc = (req_rect_h[9:0] > 10'(avail_h)) ? avail_h : req_rect_h[SW-1:0];
   assign fill_empty = req_rect_w[10] || (req_rect_w == '0) ||
                       req_rect_h[10] || (req_rect_h == '0) ||
                       !(x_neg || x_in) || !(y_neg || y_in) ||
                       (wc == '0) || (hc == '0);

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      row_start_in = row_start_ff;
      col_in       = col_ff;
      col_last_in  = col_last_ff;
      row_left_in  = row_left_ff;
      color_in     = color_ff;
      on_screen_in = on_screen_ff;
      rsp_valid_in = rsp_valid_ff & !rsp_ready;
      rsp_color_in = rsp_color_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_waddr    = pix_addr;
      mem_wdata    = fbrf_pkg::swap16(req_pixel_color);
      unique case (state_ff)
         fbrf_pkg::ST_IDLE: begin
            if (req_xfer) begin
               case (fbrf_pkg::op_type'(req_op))
                  fbrf_pkg::OP_DRAW: mem_we = on_screen;
                  fbrf_pkg::OP_FILL: begin
                     if (!fill_empty) begin
                        addr_in      = pix_addr;
                        row_start_in = pix_addr;
                        col_in       = '0;
                        col_last_in  = CW'(wc - SW'(1));
                        row_left_in  = RW'(hc - SW'(1));
                        color_in     = fbrf_pkg::swap16(req_pixel_color);
                        state_in     = fbrf_pkg::ST_FILL;
                     end
                  end
                  fbrf_pkg::OP_GET: begin
                     mem_re       = on_screen;
                     on_screen_in = on_screen;
                     state_in     = fbrf_pkg::ST_READ;
                  end
                  default: state_in = fbrf_pkg::ST_IDLE;
               endcase
            end
         end
         fbrf_pkg::ST_FILL: begin
            mem_we    = 1'b1;
            mem_waddr = addr_ff;
            mem_wdata = color_ff;
            if (col_ff == col_last_ff) begin
               if (row_left_ff == '0) begin
                  state_in = fbrf_pkg::ST_IDLE;
               end else begin
                  row_start_in = row_start_ff + AW'(sw_eff);
                  addr_in      = row_start_ff + AW'(sw_eff);
                  col_in       = '0;
                  row_left_in  = row_left_ff - RW'(1);
               end
            end else begin
               addr_in = addr_ff + AW'(1);
               col_in  = col_ff + CW'(1);
            end
         end
         fbrf_pkg::ST_READ: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_color_in = on_screen_ff ? fbrf_pkg::swap16(rdata_ff) : '0;
               state_in     = fbrf_pkg::ST_IDLE;
            end
         end
         default: state_in = fbrf_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= mem[pix_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= fbrf_pkg::WIDTH_RESET;
         height_ff    <= fbrf_pkg::HEIGHT_RESET;
         state_ff     <= fbrf_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff      <= addr_in;
      row_start_ff <= row_start_in;
      col_ff       <= col_in;
      col_last_ff  <= col_last_in;
      row_left_ff  <= row_left_in;
      color_ff     <= color_in;
      on_screen_ff <= on_screen_in;
      rsp_color_ff <= rsp_color_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_color = rsp_color_ff;

endmodule

FILE: tb/framebuffer_pixel_rect_fill_test.sv
// Self-checking testbench for the frame store with pixel draw, clipped rectangle fill and read.
module framebuffer_pixel_rect_fill_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_COLS = fbrf_pkg::MAX_COLS;
   localparam int MAX_ROWS = fbrf_pkg::MAX_ROWS;
   localparam int DEPTH    = fbrf_pkg::DEPTH;
   localparam int SIZE_W   = fbrf_pkg::SIZE_W;
   localparam int COORD_W  = fbrf_pkg::COORD_W;
   localparam int COLOR_W  = fbrf_pkg::COLOR_W;
   localparam int CSR_AW   = fbrf_pkg::CSR_AW;
   localparam int CSR_DW   = fbrf_pkg::CSR_DW;

   typedef struct {
      fbrf_pkg::op_type          op;
      logic signed [COORD_W-1:0] pos_x;
      logic signed [COORD_W-1:0] pos_y;
      logic signed [COORD_W-1:0] rect_w;
      logic signed [COORD_W-1:0] rect_h;
      logic [COLOR_W-1:0]        color;
   } pixel_cmd_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [1:0]                req_op = fbrf_pkg::OP_NONE;
   logic signed [COORD_W-1:0] req_pos_x = '0;
   logic signed [COORD_W-1:0] req_pos_y = '0;
   logic signed [COORD_W-1:0] req_rect_w = '0;
   logic signed [COORD_W-1:0] req_rect_h = '0;
   logic [COLOR_W-1:0]        req_pixel_color = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [COLOR_W-1:0]        rsp_read_color;
   logic                      csr_psel = 1'b0;
   logic                      csr_penable = 1'b0;
   logic                      csr_pwrite = 1'b0;
   logic [CSR_AW-1:0]         csr_paddr = '0;
   logic [CSR_DW-1:0]         csr_pwdata = '0;
   logic [CSR_DW-1:0]         csr_prdata;
   logic                      csr_pready;

   logic [COLOR_W-1:0]        frame_colors [DEPTH];
   logic [COLOR_W-1:0]        expected_colors [$];
   logic [SIZE_W-1:0]         cfg_width = fbrf_pkg::WIDTH_RESET;
   logic [SIZE_W-1:0]         cfg_height = fbrf_pkg::HEIGHT_RESET;
   logic signed [COORD_W-1:0] last_x = '0;
   logic signed [COORD_W-1:0] last_y = '0;

   int tx_gap_max = 0;
   int rx_gap_max = 0;
   int rx_hold_cycles = 0;
   int mismatches = 0;
   int results_seen = 0;
   int ops_sent = 0;
   int draws = 0;
   int fills = 0;
   int reads = 0;
   int pixels_filled = 0;
   int screens = 0;

   framebuffer_pixel_rect_fill i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_op(req_op),
      .req_pos_x(req_pos_x),
      .req_pos_y(req_pos_y),
      .req_rect_w(req_rect_w),
      .req_rect_h(req_rect_h),
      .req_pixel_color(req_pixel_color),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_read_color(rsp_read_color),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #6 clock = ~clock;

   task automatic report_mismatch(string what, int unsigned want, int unsigned got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("mismatch: %s expected %h got %h", what, want, got);
      end
   endtask

   // colours are kept as written, so a read predicts the stored value unchanged
   task automatic update_frame_model(pixel_cmd_type cmd);
      int  cols;
      int  rows;
      int  x;
      int  y;
      int  w;
      int  h;
      bit  on_screen;
      cols = (cfg_width > MAX_COLS) ? MAX_COLS : int'(cfg_width);
      rows = (cfg_height > MAX_ROWS) ? MAX_ROWS : int'(cfg_height);
      x = int'(cmd.pos_x);
      y = int'(cmd.pos_y);
      w = int'(cmd.rect_w);
      h = int'(cmd.rect_h);
      on_screen = (x >= 0) && (x < cols) && (y >= 0) && (y < rows);
      ops_sent++;
      case (cmd.op)
         fbrf_pkg::OP_DRAW: begin
            draws++;
            last_x = cmd.pos_x;
            last_y = cmd.pos_y;
            if (on_screen) frame_colors[y * cols + x] = cmd.color;
         end
         fbrf_pkg::OP_FILL: begin
            fills++;
            if (!(w <= 0 || h <= 0 || x >= cols || y >= rows)) begin
               if (x < 0) x = 0;
               if (y < 0) y = 0;
               if (x + w > cols) w = cols - x;
               if (y + h > rows) h = rows - y;
               for (int r = 0; r < h; r++) begin
                  for (int c = 0; c < w; c++) begin
                     frame_colors[(y + r) * cols + x + c] = cmd.color;
                  end
               end
               pixels_filled += w * h;
            end
         end
         fbrf_pkg::OP_GET: begin
            reads++;
            expected_colors.push_back(on_screen ? frame_colors[y * cols + x] : '0);
         end
         default: ;
      endcase
   endtask

   task automatic issue_pixel_op(pixel_cmd_type cmd);
      int gap;
      gap = $urandom_range(0, tx_gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_op <= cmd.op;
      req_pos_x <= cmd.pos_x;
      req_pos_y <= cmd.pos_y;
      req_rect_w <= cmd.rect_w;
      req_rect_h <= cmd.rect_h;
      req_pixel_color <= cmd.color;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      update_frame_model(cmd);
   endtask

   task automatic issue_op(fbrf_pkg::op_type op, int x, int y, int w, int h, int color);
      pixel_cmd_type cmd;
      cmd.op = op;
      cmd.pos_x = COORD_W'(x);
      cmd.pos_y = COORD_W'(y);
      cmd.rect_w = COORD_W'(w);
      cmd.rect_h = COORD_W'(h);
      cmd.color = COLOR_W'(color);
      issue_pixel_op(cmd);
   endtask

   task automatic wait_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_colors.size() != 0);
   endtask

   // drain results, then let any running fill finish
   task automatic settle_block();
      wait_results();
      repeat (3) @(posedge clock);
      while (!req_ready) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic csr_access(fbrf_pkg::reg_index_type idx, bit write,
                             logic [SIZE_W-1:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= write;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= {(CSR_DW - SIZE_W)'($urandom), value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (!write) begin
         if (csr_prdata !== CSR_DW'(value)) begin
            report_mismatch(idx == fbrf_pkg::REG_WIDTH ? "screen_width" : "screen_height",
                            value, csr_prdata);
         end
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_screen(int w, int h);
      csr_access(fbrf_pkg::REG_WIDTH, 1'b1, SIZE_W'(w));
      csr_access(fbrf_pkg::REG_HEIGHT, 1'b1, SIZE_W'(h));
      cfg_width = SIZE_W'(w);
      cfg_height = SIZE_W'(h);
      csr_access(fbrf_pkg::REG_WIDTH, 1'b0, cfg_width);
      csr_access(fbrf_pkg::REG_HEIGHT, 1'b0, cfg_height);
      screens++;
   endtask

   function automatic logic signed [COORD_W-1:0] pick_coord(int span);
      int sel;
      sel = $urandom_range(0, 9);
      case (sel)
         0, 1: return COORD_W'($urandom);
         2: return COORD_W'(span - 2 + $urandom_range(0, 3));
         3: return COORD_W'(-$urandom_range(1, 4));
         default: return (span > 0) ? COORD_W'($urandom_range(0, span - 1))
                                    : COORD_W'($urandom_range(0, 3));
      endcase
   endfunction

   function automatic pixel_cmd_type random_cmd();
      pixel_cmd_type cmd;
      int            sel;
      int            cols;
      int            rows;
      cols = (cfg_width > MAX_COLS) ? MAX_COLS : int'(cfg_width);
      rows = (cfg_height > MAX_ROWS) ? MAX_ROWS : int'(cfg_height);
      sel = $urandom_range(0, 99);
      if (sel < 5) cmd.op = fbrf_pkg::OP_NONE;
      else if (sel < 40) cmd.op = fbrf_pkg::OP_DRAW;
      else if (sel < 65) cmd.op = fbrf_pkg::OP_FILL;
      else cmd.op = fbrf_pkg::OP_GET;
      cmd.pos_x = pick_coord(cols);
      cmd.pos_y = pick_coord(rows);
      cmd.rect_w = COORD_W'($urandom);
      cmd.rect_h = COORD_W'($urandom);
      cmd.color = COLOR_W'($urandom);
      if (cmd.op == fbrf_pkg::OP_FILL) begin
         cmd.rect_w = COORD_W'($urandom_range(1, 8));
         cmd.rect_h = COORD_W'($urandom_range(1, 8));
         case ($urandom_range(0, 9))
            0: cmd.rect_w = COORD_W'($urandom);
            1: cmd.rect_h = COORD_W'($urandom);
            2: cmd.rect_w = COORD_W'(-$urandom_range(0, 1024));
            3: cmd.rect_h = COORD_W'(-$urandom_range(0, 1024));
            default: ;
         endcase
      end
      if (cmd.op == fbrf_pkg::OP_GET && $urandom_range(0, 2) == 0) begin
         cmd.pos_x = last_x;
         cmd.pos_y = last_y;
      end
      return cmd;
   endfunction

   always @(posedge clock) begin
      logic [COLOR_W-1:0] want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (expected_colors.size() == 0) begin
            report_mismatch("unexpected read transfer", 0, rsp_read_color);
         end else begin
            want = expected_colors.pop_front();
            if (rsp_read_color !== want) report_mismatch("read_color", want, rsp_read_color);
         end
      end
   end

   initial begin
      int stall;
      while (reset) @(posedge clock);
      forever begin
         if (rx_hold_cycles > 0) begin
            stall = rx_hold_cycles;
            rx_hold_cycles = 0;
         end else begin
            stall = $urandom_range(0, rx_gap_max);
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   // only pixels drawn here are read before the whole store has been filled
   task automatic test_reset_defaults();
      csr_access(fbrf_pkg::REG_WIDTH, 1'b0, fbrf_pkg::WIDTH_RESET);
      csr_access(fbrf_pkg::REG_HEIGHT, 1'b0, fbrf_pkg::HEIGHT_RESET);
      issue_op(fbrf_pkg::OP_DRAW, 0, 0, 0, 0, 'hFFFF);
      issue_op(fbrf_pkg::OP_GET, 0, 0, 0, 0, 0);
      issue_op(fbrf_pkg::OP_DRAW, 239, 239, -1, 1023, 'h0001);
      issue_op(fbrf_pkg::OP_GET, 239, 239, 0, 0, 0);
      issue_op(fbrf_pkg::OP_DRAW, 240, 239, 0, 0, 'h1234);
      issue_op(fbrf_pkg::OP_GET, 240, 0, 0, 0, 0);
      issue_op(fbrf_pkg::OP_GET, 0, -1, 0, 0, 0);
      issue_op(fbrf_pkg::OP_NONE, 0, 0, 5, 5, 'hAAAA);
      issue_op(fbrf_pkg::OP_GET, -1024, 1023, 0, 0, 0);
      settle_block();
   endtask

   task automatic test_clear_screen();
      set_screen(MAX_COLS, MAX_ROWS);
      issue_op(fbrf_pkg::OP_FILL, -1024, -1024, 1023, 1023, 'h0000);
      issue_op(fbrf_pkg::OP_GET, 255, 255, 0, 0, 0);
      settle_block();
   endtask

   task automatic test_fill_clipping();
      issue_op(fbrf_pkg::OP_FILL, 10, 10, 0, 5, 'h5555);
      issue_op(fbrf_pkg::OP_FILL, 10, 10, 5, -1024, 'h5555);
      issue_op(fbrf_pkg::OP_FILL, 256, 0, 4, 4, 'h6666);
      issue_op(fbrf_pkg::OP_FILL, 0, 256, 4, 4, 'h6666);
      issue_op(fbrf_pkg::OP_GET, 10, 10, 0, 0, 0);
      issue_op(fbrf_pkg::OP_FILL, -3, -2, 5, 4, 'hC3A5);
      issue_op(fbrf_pkg::OP_GET, 4, 3, 0, 0, 0);
      issue_op(fbrf_pkg::OP_GET, 5, 0, 0, 0, 0);
      issue_op(fbrf_pkg::OP_FILL, 250, 252, 1023, 1023, 'h7E81);
      issue_op(fbrf_pkg::OP_GET, 255, 255, 0, 0, 0);
      issue_op(fbrf_pkg::OP_GET, 1023, 1023, 0, 0, 0);
      settle_block();
   endtask

   task automatic test_backpressure();
      pixel_cmd_type cmd;
      tx_gap_max = 0;
      rx_gap_max = 0;
      repeat (2) begin
         rx_hold_cycles = 300;
         issue_op(fbrf_pkg::OP_GET, 4, 3, 0, 0, 0);
         repeat (40) begin
            cmd = random_cmd();
            if (cmd.op == fbrf_pkg::OP_FILL) cmd.op = fbrf_pkg::OP_GET;
            issue_pixel_op(cmd);
         end
         wait_results();
      end
      settle_block();
   endtask

   task automatic test_screen_sizes();
      int widths[10] = '{1, 0, 511, 16, 240, 257, 100, 256, 1, 256};
      int heights[10] = '{1, 0, 511, 9, 240, 300, 37, 1, 256, 256};
      for (int i = 0; i < 10; i++) begin
         set_screen(widths[i], heights[i]);
         case (i % 3)
            0: begin tx_gap_max = 15; rx_gap_max = 15; end
            1: begin tx_gap_max = 0; rx_gap_max = 0; end
            default: begin tx_gap_max = i % 2 ? 15 : 0; rx_gap_max = i % 2 ? 0 : 15; end
         endcase
         issue_op(fbrf_pkg::OP_FILL, -$urandom_range(0, 1024), -$urandom_range(0, 1024),
                  1023, 1023, $urandom);
         repeat (170) begin
            issue_pixel_op(random_cmd());
            if ($urandom_range(0, 49) == 0) wait_results();
         end
         settle_block();
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_clear_screen();
      test_fill_clipping();
      test_backpressure();
      test_screen_sizes();
      settle_block();
      repeat (20) @(posedge clock);
      $display("Ran %0d requests: %0d draws, %0d fills covering %0d pixels, %0d reads.",
               ops_sent, draws, fills, pixels_filled, reads);
      $display("Checked %0d read transfers over %0d screen sizes, %0d mismatches.",
               results_seen, screens, mismatches);
      if (expected_colors.size() != 0) begin
         $display("%0d read results never arrived", expected_colors.size());
      end
      if (mismatches == 0 && expected_colors.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #200_000_000;
      $display("timeout: %0d read results outstanding", expected_colors.size());
      $display("CHECK FAILED");
      $finish;
   end

endmodule
